// ===== rtl/tce_pkg.sv =====
// Package for the tricorn escape-time block: shared constants, codes and the
// command/status types between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package tce_pkg;

   // Fixed field widths.
   localparam int CODE_W      = 21;
   localparam int RADIUS_W    = 47;
   localparam int TRIG_W      = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 47;

   // Rotation coefficients are Q1.30.
   localparam int ROT_SHIFT = 30;

   // Color code construction: count*8, plus an offset for a negative final
   // imaginary part.
   localparam int CODE_SCALE_SHIFT = 3;
   localparam int DECOMP_OFFSET    = 21;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ITER  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS_SQ = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROT_COS   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROT_SIN   = 4'd3;

   // Register reset values.
   localparam int                    MAX_ITER_RESET  = 100;
   localparam logic [RADIUS_W-1:0]   RADIUS_RESET    = 47'd2684354560000;
   localparam logic [TRIG_W-1:0]     ROT_COS_RESET   = 32'h4000_0000;
   localparam logic [TRIG_W-1:0]     ROT_SIN_RESET   = 32'h0000_0000;

   // Operand selection for the multiplier lanes.
   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_ROT_A = 2'd0;
   localparam mul_sel_type MUL_ROT_B = 2'd1;
   localparam mul_sel_type MUL_ORBIT = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;       // capture the input point
      logic        mul_start;  // launch all multiplier lanes
      mul_sel_type mul_sel;    // operand set for the launch
      logic        cap_rot_a;  // store first rotation products
      logic        cap_rot_b;  // form c and clear the orbit
      logic        step;       // advance z and the count
      logic        cap_orbit;  // store the orbit products
      logic        load_rsp;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mul_done;
      logic stop;
   } status_type;

endpackage

// ===== rtl/tce_if.sv =====
// Handshake channel interfaces of the tricorn escape-time block: input
// points, result codes and configuration writes. Uses tce_pkg.
`timescale 1ns / 1ps

interface tce_point_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_re;
   logic signed [COORD_WIDTH-1:0] point_im;

   modport source (output valid, output point_re, output point_im, input ready);
   modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

interface tce_color_if;
   logic                               valid;
   logic                               ready;
   logic signed [tce_pkg::CODE_W-1:0]  color_code;

   modport source (output valid, output color_code, input ready);
   modport sink   (input valid, input color_code, output ready);
endinterface

interface tce_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tce_pkg::CSR_INDEX_W-1:0]  index;
   logic [tce_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/tce_mul.sv =====
// Digit-serial unsigned multiplier lane: 16 bits of b per cycle, then a
// right shift by one of two constants with saturation. Uses no package.
`timescale 1ns / 1ps

module tce_mul #(
   parameter int AW      = 48,
   parameter int BW      = 47,
   parameter int SH_FRAC = 28,
   parameter int SH_ROT  = 30,
   parameter int RES_W   = 47
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             rot_sel,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [RES_W-1:0] res,
   output logic             sat
);

   localparam int DIGIT_W = 16;
   localparam int NCH     = (BW + DIGIT_W - 1) / DIGIT_W;
   localparam int PB      = NCH * DIGIT_W;
   localparam int ACC_W   = AW + PB;
   localparam int CNT_W   = $clog2(NCH + 1);

   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rot_ff, rot_in;
   logic [AW-1:0]      a_ff, a_in;
   logic [PB-1:0]      b_ff, b_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [RES_W-1:0]   res_ff, res_in;
   logic               sat_ff, sat_in;

   logic [AW+DIGIT_W-1:0] partial;
   logic [ACC_W-1:0]      shifted;
   logic                  over;

   // One digit product per cycle, most significant digit first.
   assign partial = a_ff * b_ff[PB-1 -: DIGIT_W];

   // Scale the finished product and clamp to the largest magnitude.
   assign shifted = rot_ff ? (acc_ff >> SH_ROT) : (acc_ff >> SH_FRAC);
   assign over    = |shifted[ACC_W-1:RES_W];

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rot_in  = rot_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NCH);
         rot_in  = rot_sel;
         a_in    = a;
         b_in    = PB'(b);
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff << DIGIT_W) + ACC_W'(partial);
         b_in   = b_ff << DIGIT_W;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         res_in  = over ? '1 : shifted[RES_W-1:0];
         sat_in  = over;
         done_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   // Operand and result registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rot_ff <= rot_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign res  = res_ff;
   assign sat  = sat_ff;

endmodule

// ===== rtl/tce_datapath.sv =====
// Datapath of the tricorn escape-time block: configuration registers, the
// point rotation, the orbit registers and three multiplier lanes.
// Uses tce_pkg and tce_mul.
`timescale 1ns / 1ps

module tce_datapath #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28,
   parameter int ITER_WIDTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tce_pkg::cmd_type                    cmd,
   output tce_pkg::status_type                 status,
   input  logic signed [COORD_WIDTH-1:0]       point_re,
   input  logic signed [COORD_WIDTH-1:0]       point_im,
   input  logic                                csr_write,
   input  logic [tce_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tce_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic signed [tce_pkg::CODE_W-1:0]   color_code
);

   localparam int INNER_W = (FRAC_BITS + 20 > 63) ? 63 : FRAC_BITS + 20;
   localparam int MAG_W   = INNER_W - 1;
   localparam int TW      = tce_pkg::TRIG_W;
   localparam int AW      = (INNER_W > TW) ? INNER_W : TW;
   localparam int BW      = (MAG_W > COORD_WIDTH) ? MAG_W : COORD_WIDTH;
   localparam int RW      = tce_pkg::RADIUS_W;
   localparam int CMP_W   = ((INNER_W > RW) ? INNER_W : RW) + 1;
   localparam int CALC_W  = (ITER_WIDTH + 4 > tce_pkg::CODE_W) ?
                            ITER_WIDTH + 4 : tce_pkg::CODE_W;

   localparam logic signed [INNER_W:0] SUM_MAX = {2'b00, {(INNER_W-1){1'b1}}};
   localparam logic signed [INNER_W:0] SUM_MIN = -SUM_MAX;

   // Saturating add to the symmetric inner range.
   function automatic logic signed [INNER_W-1:0] sat_add(
      input logic signed [INNER_W-1:0] x,
      input logic signed [INNER_W-1:0] y
   );
      logic signed [INNER_W:0] s;
      s = $signed({x[INNER_W-1], x}) + $signed({y[INNER_W-1], y});
      if (s > SUM_MAX)
         return $signed(SUM_MAX[INNER_W-1:0]);
      else if (s < SUM_MIN)
         return $signed(SUM_MIN[INNER_W-1:0]);
      else
         return $signed(s[INNER_W-1:0]);
   endfunction

   // Attach a sign to a lane magnitude.
   function automatic logic signed [INNER_W-1:0] apply_sign(
      input logic             neg,
      input logic [MAG_W-1:0] m
   );
      logic signed [INNER_W-1:0] v;
      v = $signed({1'b0, m});
      return neg ? -v : v;
   endfunction

   // Configuration registers.
   logic [ITER_WIDTH-1:0]  max_iter_ff;
   logic [RW-1:0]          radius_ff;
   logic signed [TW-1:0]   cos_ff;
   logic signed [TW-1:0]   sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ITER_WIDTH'(tce_pkg::MAX_ITER_RESET);
         radius_ff   <= tce_pkg::RADIUS_RESET;
         cos_ff      <= $signed(tce_pkg::ROT_COS_RESET);
         sin_ff      <= $signed(tce_pkg::ROT_SIN_RESET);
      end else if (csr_write) begin
         case (csr_index)
            tce_pkg::REG_MAX_ITER:  max_iter_ff <= csr_wdata[ITER_WIDTH-1:0];
            tce_pkg::REG_RADIUS_SQ: radius_ff   <= csr_wdata[RW-1:0];
            tce_pkg::REG_ROT_COS:   cos_ff      <= $signed(csr_wdata[TW-1:0]);
            tce_pkg::REG_ROT_SIN:   sin_ff      <= $signed(csr_wdata[TW-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Point and orbit registers.
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff;
   logic signed [INNER_W-1:0]     t0_ff, t1_ff, t2_ff;
   logic signed [INNER_W-1:0]     cre_ff, cim_ff;
   logic signed [INNER_W-1:0]     re_ff, im_ff;
   logic [MAG_W-1:0]              p_ff, re2_ff, im2_ff;
   logic                          sat_ff;
   logic [ITER_WIDTH-1:0]         iter_ff;
   logic signed [tce_pkg::CODE_W-1:0] color_ff;

   // Operand magnitudes.
   logic [COORD_WIDTH-1:0] x_mag, y_mag;
   logic [TW-1:0]          cos_mag, sin_mag;
   logic [INNER_W-1:0]     re_abs, im_abs;
   logic [MAG_W-1:0]       re_mag, im_mag;

   assign x_mag   = x_ff[COORD_WIDTH-1] ? $unsigned(-x_ff) : $unsigned(x_ff);
   assign y_mag   = y_ff[COORD_WIDTH-1] ? $unsigned(-y_ff) : $unsigned(y_ff);
   assign cos_mag = cos_ff[TW-1] ? $unsigned(-cos_ff) : $unsigned(cos_ff);
   assign sin_mag = sin_ff[TW-1] ? $unsigned(-sin_ff) : $unsigned(sin_ff);
   assign re_abs  = re_ff[INNER_W-1] ? $unsigned(-re_ff) : $unsigned(re_ff);
   assign im_abs  = im_ff[INNER_W-1] ? $unsigned(-im_ff) : $unsigned(im_ff);
   assign re_mag  = re_abs[MAG_W-1:0];
   assign im_mag  = im_abs[MAG_W-1:0];

   // Lane operand selection.
   logic [AW-1:0] l0_a, l1_a, l2_a;
   logic [BW-1:0] l0_b, l1_b, l2_b;
   logic          rot_sel;

   always_comb begin
      rot_sel = 1'b1;
      l0_a = AW'(cos_mag);
      l0_b = BW'(x_mag);
      l1_a = AW'(sin_mag);
      l1_b = BW'(y_mag);
      l2_a = AW'(sin_mag);
      l2_b = BW'(x_mag);
      case (cmd.mul_sel)
         tce_pkg::MUL_ROT_A: begin
         end
         tce_pkg::MUL_ROT_B: begin
            l0_b = BW'(y_mag);
         end
         tce_pkg::MUL_ORBIT: begin
            rot_sel = 1'b0;
            l0_a = AW'({re_mag, 1'b0});
            l0_b = BW'(im_mag);
            l1_a = AW'(re_mag);
            l1_b = BW'(re_mag);
            l2_a = AW'(im_mag);
            l2_b = BW'(im_mag);
         end
         default: begin
         end
      endcase
   end

   logic             d0, d1, d2;
   logic [MAG_W-1:0] r0, r1, r2;
   logic             s0, s1, s2;

   tce_mul #(.AW(AW), .BW(BW), .SH_FRAC(FRAC_BITS), .SH_ROT(tce_pkg::ROT_SHIFT),
             .RES_W(MAG_W)) u_lane0 (
      .clock(clock), .reset(reset), .start(cmd.mul_start), .rot_sel(rot_sel),
      .a(l0_a), .b(l0_b), .done(d0), .res(r0), .sat(s0));

   tce_mul #(.AW(AW), .BW(BW), .SH_FRAC(FRAC_BITS), .SH_ROT(tce_pkg::ROT_SHIFT),
             .RES_W(MAG_W)) u_lane1 (
      .clock(clock), .reset(reset), .start(cmd.mul_start), .rot_sel(rot_sel),
      .a(l1_a), .b(l1_b), .done(d1), .res(r1), .sat(s1));

   tce_mul #(.AW(AW), .BW(BW), .SH_FRAC(FRAC_BITS), .SH_ROT(tce_pkg::ROT_SHIFT),
             .RES_W(MAG_W)) u_lane2 (
      .clock(clock), .reset(reset), .start(cmd.mul_start), .rot_sel(rot_sel),
      .a(l2_a), .b(l2_b), .done(d2), .res(r2), .sat(s2));

   // Signed rotation products as they leave the lanes.
   logic signed [INNER_W-1:0] prod_cx, prod_sy, prod_sx, prod_cy;

   assign prod_cx = apply_sign(cos_ff[TW-1] ^ x_ff[COORD_WIDTH-1], r0);
   assign prod_sy = apply_sign(sin_ff[TW-1] ^ y_ff[COORD_WIDTH-1], r1);
   assign prod_sx = apply_sign(sin_ff[TW-1] ^ x_ff[COORD_WIDTH-1], r2);
   assign prod_cy = apply_sign(cos_ff[TW-1] ^ y_ff[COORD_WIDTH-1], r0);

   // Next z: im' = -2*re*im + im(c), re' = re^2 - im^2 + re(c).
   logic                      neg_ri;
   logic signed [INNER_W-1:0] minus_two_ri;
   logic signed [INNER_W-1:0] sq_diff;
   logic signed [INNER_W-1:0] re_next, im_next;

   assign neg_ri       = re_ff[INNER_W-1] ^ im_ff[INNER_W-1];
   assign minus_two_ri = apply_sign(~neg_ri, p_ff);
   assign sq_diff      = $signed({1'b0, re2_ff}) - $signed({1'b0, im2_ff});
   assign im_next      = sat_add(minus_two_ri, cim_ff);
   assign re_next      = sat_add(sq_diff, cre_ff);

   // Escape test and result code.
   logic                       at_limit;
   logic [CMP_W-1:0]           modulus_sq;
   logic [CALC_W-1:0]          code_wide;
   logic signed [tce_pkg::CODE_W-1:0] color_next;

   assign at_limit   = (iter_ff >= max_iter_ff);
   assign modulus_sq = CMP_W'(re2_ff) + CMP_W'(im2_ff);
   assign code_wide  = (CALC_W'(iter_ff) << tce_pkg::CODE_SCALE_SHIFT) +
                       (im_ff[INNER_W-1] ? CALC_W'(tce_pkg::DECOMP_OFFSET) : '0);
   assign color_next = at_limit ? '1 : $signed(code_wide[tce_pkg::CODE_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= point_re;
         y_ff <= point_im;
      end
      if (cmd.cap_rot_a) begin
         t0_ff <= prod_cx;
         t1_ff <= prod_sy;
         t2_ff <= prod_sx;
      end
      if (cmd.cap_rot_b) begin
         cre_ff  <= sat_add(t0_ff, -t1_ff);
         cim_ff  <= sat_add(t2_ff, prod_cy);
         re_ff   <= '0;
         im_ff   <= '0;
         p_ff    <= '0;
         re2_ff  <= '0;
         im2_ff  <= '0;
         sat_ff  <= 1'b0;
         iter_ff <= '0;
      end
      if (cmd.step) begin
         re_ff   <= re_next;
         im_ff   <= im_next;
         iter_ff <= iter_ff + ITER_WIDTH'(1);
      end
      if (cmd.cap_orbit) begin
         p_ff   <= r0;
         re2_ff <= r1;
         im2_ff <= r2;
         sat_ff <= s1 | s2;
      end
      if (cmd.load_rsp)
         color_ff <= color_next;
   end

   assign status.mul_done = d0 & d1 & d2;
   assign status.stop     = at_limit | sat_ff | (modulus_sq >= CMP_W'(radius_ff));
   assign color_code      = color_ff;

endmodule

// ===== rtl/tce_ctrl.sv =====
// Controller of the tricorn escape-time block: sequences rotation, orbit
// iterations and the result register handshake. Uses tce_pkg.
`timescale 1ns / 1ps

module tce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tce_pkg::status_type  status,
   output tce_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_START    = 3'd1;
   localparam logic [2:0] S_ROT_A    = 3'd2;
   localparam logic [2:0] S_ROT_B    = 3'd3;
   localparam logic [2:0] S_CHECK    = 3'd4;
   localparam logic [2:0] S_ORBIT_GO = 3'd5;
   localparam logic [2:0] S_ORBIT    = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = tce_pkg::MUL_ROT_A;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.mul_start = 1'b1;
            state_in      = S_ROT_A;
         end
         S_ROT_A: begin
            if (status.mul_done) begin
               cmd.cap_rot_a = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = tce_pkg::MUL_ROT_B;
               state_in      = S_ROT_B;
            end
         end
         S_ROT_B: begin
            if (status.mul_done) begin
               cmd.cap_rot_b = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.stop) begin
               state_in = S_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = S_ORBIT_GO;
            end
         end
         S_ORBIT_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = tce_pkg::MUL_ORBIT;
            state_in      = S_ORBIT;
         end
         S_ORBIT: begin
            cmd.mul_sel = tce_pkg::MUL_ORBIT;
            if (status.mul_done) begin
               cmd.cap_orbit = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result register stays full until its transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/tricorn_escape_time.sv =====
// Tricorn escape-time block, top level: joins controller and datapath to the
// point, result and configuration channels. Uses tce_pkg, tce_if, tce_ctrl,
// tce_datapath.
`timescale 1ns / 1ps

// One point is taken at a time. It is rotated by the configured cosine and
// sine, then z -> conj(z)^2 + c is iterated from zero until the squared
// modulus reaches the escape radius, a square saturates, or the count reaches
// max_iter; the color code is -1, count*8 or count*8+21. Every multiplication
// runs on one of three digit-serial lanes that consume b in NCH = ceil(max(
// COORD_WIDTH, INNER-1)/16) digits of 16 bits (INNER = FRAC_BITS+20, at most
// 63). The next point is accepted once the finished code sits in the output
// register, which holds it until its transfer. Configuration writes are always
// taken and act at once, also on a point in work, so they belong between
// points.

module tricorn_escape_time #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 28,
   parameter int ITER_WIDTH  = 16
) (
   input  logic         clock,
   input  logic         reset,
   tce_point_if.sink    req_if,
   tce_color_if.source  rsp_if,
   tce_csr_if.sink      csr_if
);

   tce_pkg::cmd_type    cmd;
   tce_pkg::status_type status;

   tce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tce_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .ITER_WIDTH  (ITER_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .point_re   (req_if.point_re),
      .point_im   (req_if.point_im),
      .csr_write  (csr_if.valid),
      .csr_index  (csr_if.index),
      .csr_wdata  (csr_if.wdata),
      .color_code (rsp_if.color_code)
   );

   // Configuration writes complete in the cycle they are offered.
   assign csr_if.ready = 1'b1;

endmodule

// ===== rtl/tce_checker.sv =====
// Port-level checks for the tricorn escape-time block, attached to the top
// level by a bind. Uses tce_pkg.
`timescale 1ns / 1ps

module tce_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [tce_pkg::CODE_W-1:0] color_code
);

   // A point in work keeps the input side closed.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again right after a transfer");

   // A new result appears only after work with the input side closed.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the input side was open");

   // Codes are -1, count*8 or count*8+21.
   a_code_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (color_code == '1) || (color_code[2:0] == 3'b000) ||
                    (color_code[2:0] == 3'b101))
      else $error("malformed color code");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(color_code))
      else $error("result changed while stalled");

endmodule

bind tricorn_escape_time tce_checker u_tce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .color_code (rsp_if.color_code)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the tricorn escape-time block: directed and random
// plane points, register settings and back-pressure, checked against a local predictor.
// Depends on tce_pkg, tce_if and the tricorn_escape_time top level.
`timescale 1ns / 1ps

module tb_top;

   localparam int COORD_WIDTH    = 32;
   localparam int FRAC_BITS      = 28;
   localparam int ITER_WIDTH     = 16;
   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int HOLD_OFF       = 3000;

   // Largest magnitude of an internal Q20.28 value.
   localparam logic [63:0] INNER_MAX = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic signed [tce_pkg::CODE_W-1:0] INSIDE_CODE = '1;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 32'sh8000_0000;
   localparam longint TRIG_ONE = 64'sd1073741824;

   logic clock = 1'b0;
   logic reset;

   tce_point_if #(.COORD_WIDTH(COORD_WIDTH)) req_if ();
   tce_color_if rsp_if ();
   tce_csr_if   csr_if ();

   tricorn_escape_time #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ITER_WIDTH (ITER_WIDTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   // Local copy of the configuration registers.
   logic [ITER_WIDTH-1:0]             cfg_max_iter;
   logic [tce_pkg::RADIUS_W-1:0]      cfg_radius_sq;
   logic signed [tce_pkg::TRIG_W-1:0] cfg_rot_cos;
   logic signed [tce_pkg::TRIG_W-1:0] cfg_rot_sin;

   logic signed [tce_pkg::CODE_W-1:0] expected_codes[$];
   int unsigned error_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_cycles   = 0;
   int unsigned quiet_cycles  = 0;

   always #(CLK_HALF) clock = ~clock;

   // Unsigned product shifted right, clipped to the internal range.
   function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                             input int unsigned sh, output bit clipped);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) >> sh;
      clipped = (prod > {64'd0, INNER_MAX});
      return clipped ? INNER_MAX : prod[63:0];
   endfunction

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Signed product: the magnitude is truncated, then the sign is applied.
   function automatic longint mul_signed(input longint a, input longint b,
                                         input int unsigned sh);
      bit          clipped;
      logic [63:0] m;
      m = mul_shift(magnitude(a), magnitude(b), sh, clipped);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint sat_sum(input longint a, input longint b);
      longint r;
      r = a + b;
      if (r > longint'(INNER_MAX)) return longint'(INNER_MAX);
      if (r < -longint'(INNER_MAX)) return -longint'(INNER_MAX);
      return r;
   endfunction

   // Color code of one plane point under the current register settings.
   function automatic logic signed [tce_pkg::CODE_W-1:0] predict_color(
         input logic signed [COORD_WIDTH-1:0] pre, input logic signed [COORD_WIDTH-1:0] pim);
      longint      x, y, cs, sn, c_re, c_im, z_re, z_im, two_ri;
      logic [63:0] re_sq, im_sq, p;
      bit          clip, c1, c2, unused;
      int unsigned count;
      x  = pre;
      y  = pim;
      cs = cfg_rot_cos;
      sn = cfg_rot_sin;
      c_re = sat_sum(mul_signed(cs, x, tce_pkg::ROT_SHIFT),
                     -mul_signed(sn, y, tce_pkg::ROT_SHIFT));
      c_im = sat_sum(mul_signed(sn, x, tce_pkg::ROT_SHIFT),
                     mul_signed(cs, y, tce_pkg::ROT_SHIFT));
      z_re  = 0;
      z_im  = 0;
      re_sq = '0;
      im_sq = '0;
      clip  = 1'b0;
      count = 0;
      while (count < cfg_max_iter && !clip && (re_sq + im_sq) < {17'd0, cfg_radius_sq}) begin
         // conj(z)^2 + c, built from the squares of the previous z.
         p = mul_shift(magnitude(z_re) << 1, magnitude(z_im), FRAC_BITS, unused);
         two_ri = ((z_re < 0) != (z_im < 0)) ? -longint'(p) : longint'(p);
         z_im  = sat_sum(-two_ri, c_im);
         z_re  = sat_sum(sat_sum(longint'(re_sq), -longint'(im_sq)), c_re);
         re_sq = mul_shift(magnitude(z_re), magnitude(z_re), FRAC_BITS, c1);
         im_sq = mul_shift(magnitude(z_im), magnitude(z_im), FRAC_BITS, c2);
         clip  = c1 | c2;
         count++;
      end
      if (count >= cfg_max_iter) return INSIDE_CODE;
      if (z_im >= 0) return tce_pkg::CODE_W'(count << tce_pkg::CODE_SCALE_SHIFT);
      return tce_pkg::CODE_W'((count << tce_pkg::CODE_SCALE_SHIFT) + tce_pkg::DECOMP_OFFSET);
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] q28(input real v);
      return COORD_WIDTH'($rtoi(v * 268435456.0));
   endfunction

   // Mostly points around the set, some over the whole range, some near the origin.
   function automatic logic signed [COORD_WIDTH-1:0] random_coord(input int unsigned kind);
      if (kind < 70) return int'($urandom_range(0, 1342177280)) - 671088640;
      if (kind < 90) return $urandom;
      return int'($urandom_range(0, 268435456)) - 134217728;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] ERROR: %s", $time, what);
      error_count++;
   endtask

   // One point transfer; valid stays high afterwards so bursts run back to back.
   task automatic send_point(input logic signed [COORD_WIDTH-1:0] pre,
                             input logic signed [COORD_WIDTH-1:0] pim);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.point_re = pre;
      req_if.point_im = pim;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_codes.push_back(predict_color(pre, pim));
      @(negedge clock);
   endtask

   task automatic send_random_point();
      int unsigned kind;
      kind = $urandom_range(99);
      send_point(random_coord(kind), random_coord(kind));
   endtask

   // Lower valid, wait for every pending result, then let the block settle.
   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register write transfer; the local copy follows the accepted write.
   task automatic write_reg(input logic [tce_pkg::CSR_INDEX_W-1:0] index,
                            input logic [tce_pkg::CSR_DATA_W-1:0] data);
      csr_if.valid = 1'b1;
      csr_if.index = index;
      csr_if.wdata = data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (index)
         tce_pkg::REG_MAX_ITER:  cfg_max_iter  = data[ITER_WIDTH-1:0];
         tce_pkg::REG_RADIUS_SQ: cfg_radius_sq = data[tce_pkg::RADIUS_W-1:0];
         tce_pkg::REG_ROT_COS:   cfg_rot_cos   = data[tce_pkg::TRIG_W-1:0];
         tce_pkg::REG_ROT_SIN:   cfg_rot_sin   = data[tce_pkg::TRIG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic write_rotation(input longint cs, input longint sn);
      write_reg(tce_pkg::REG_ROT_COS, tce_pkg::CSR_DATA_W'(cs));
      write_reg(tce_pkg::REG_ROT_SIN, tce_pkg::CSR_DATA_W'(sn));
   endtask

   // Default registers: inside, outside, both signs of the final imaginary part.
   task automatic test_reset_defaults();
      send_point('0, '0);
      send_point('0, q28(-3.0));
      send_point('0, q28(3.0));
      send_point(q28(3.0), '0);
      send_point(COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN);
      wait_drained();
   endtask

   // A limit of zero reports every point as inside at once.
   task automatic test_zero_limit();
      write_reg(tce_pkg::REG_MAX_ITER, '0);
      send_point(q28(3.0), '0);
      send_point('0, '0);
      wait_drained();
      write_reg(tce_pkg::REG_MAX_ITER, tce_pkg::CSR_DATA_W'(tce_pkg::MAX_ITER_RESET));
   endtask

   // A zero radius escapes before the first iteration.
   task automatic test_zero_radius();
      write_reg(tce_pkg::REG_RADIUS_SQ, '0);
      send_point(q28(1.0), q28(1.0));
      send_point(COORD_MIN, COORD_MAX);
      wait_drained();
   endtask

   // With the largest radius the two outer points end on a saturated square and the origin runs to the limit.
   task automatic test_square_overflow();
      write_reg(tce_pkg::REG_RADIUS_SQ, {tce_pkg::CSR_DATA_W{1'b1}});
      send_point(q28(7.5), q28(7.5));
      send_point(q28(-8.0), '0);
      send_point('0, '0);
      wait_drained();
   endtask

   // Largest and smallest nonzero limits, with points that leave quickly.
   task automatic test_iteration_extremes();
      write_reg(tce_pkg::REG_RADIUS_SQ, tce_pkg::CSR_DATA_W'(64'd4 << FRAC_BITS));
      write_reg(tce_pkg::REG_MAX_ITER, tce_pkg::CSR_DATA_W'(16'hFFFF));
      send_point(q28(5.0), q28(5.0));
      send_point(q28(-6.0), q28(1.0));
      wait_drained();
      write_reg(tce_pkg::REG_MAX_ITER, tce_pkg::CSR_DATA_W'(1));
      send_point(q28(0.1), q28(0.1));
      send_point(q28(5.0), '0);
      wait_drained();
   endtask

   // Rotation coefficients at their extremes, mostly with extreme coordinates.
   task automatic test_rotation_extremes();
      write_reg(tce_pkg::REG_MAX_ITER, tce_pkg::CSR_DATA_W'(tce_pkg::MAX_ITER_RESET));
      write_reg(tce_pkg::REG_RADIUS_SQ, tce_pkg::CSR_DATA_W'(tce_pkg::RADIUS_RESET));
      write_rotation(-TRIG_ONE, 0);
      send_point(q28(1.0), q28(-2.0));
      wait_drained();
      write_rotation(0, TRIG_ONE);
      send_point(COORD_MAX, COORD_MIN);
      wait_drained();
      write_rotation(0, -TRIG_ONE);
      send_point(COORD_MIN, COORD_MIN);
      wait_drained();
      write_rotation(TRIG_ONE, TRIG_ONE);
      send_point(COORD_MAX, COORD_MAX);
      wait_drained();
   endtask

   // Writes to indexes past the register list must change nothing.
   task automatic test_unknown_index();
      for (int idx = tce_pkg::REG_ROT_SIN + 1; idx < (1 << tce_pkg::CSR_INDEX_W); idx++) begin
         write_reg(tce_pkg::CSR_INDEX_W'(idx), tce_pkg::CSR_DATA_W'({$urandom, $urandom}));
      end
      send_point(q28(0.25), q28(-0.5));
      send_point(q28(-1.8), q28(0.9));
      wait_drained();
   endtask

   // Random register setting; the block is drained first.
   task automatic apply_random_setting();
      logic [tce_pkg::RADIUS_W-1:0] radius;
      longint                       cs, sn;
      wait_drained();
      write_reg(tce_pkg::REG_MAX_ITER, tce_pkg::CSR_DATA_W'($urandom_range(1, 120)));
      case ($urandom_range(4))
         0:       radius = tce_pkg::RADIUS_W'(64'd4 << FRAC_BITS);
         1:       radius = tce_pkg::RADIUS_RESET;
         2:       radius = tce_pkg::RADIUS_W'({$urandom, $urandom});
         3:       radius = tce_pkg::RADIUS_W'($urandom);
         default: radius = {tce_pkg::RADIUS_W{1'b1}};
      endcase
      write_reg(tce_pkg::REG_RADIUS_SQ, tce_pkg::CSR_DATA_W'(radius));
      if ($urandom_range(2) == 0) begin
         cs = TRIG_ONE;
         sn = 0;
      end else begin
         cs = longint'($urandom_range(0, 32'h8000_0000)) - TRIG_ONE;
         sn = longint'($urandom_range(0, 32'h8000_0000)) - TRIG_ONE;
      end
      write_rotation(cs, sn);
   endtask

   // Random points under several settings with the given idling on each side.
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (3) begin
         apply_random_setting();
         repeat (40) send_random_point();
      end
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while points keep coming.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      apply_random_setting();
      hold_cycles = HOLD_OFF;
      repeat (8) send_random_point();
      wait_drained();
   endtask

   // Result receiver: random stalls, or a counted hold-off when requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles  <= hold_cycles - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Each result transfer is compared with the oldest pending prediction.
   always @(posedge clock) begin
      logic signed [tce_pkg::CODE_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("color_code %0d with no point pending",
                                      rsp_if.color_code));
         end else begin
            want = expected_codes.pop_front();
            if (rsp_if.color_code !== want) begin
               report_mismatch($sformatf("color_code got %0d expected %0d",
                                         rsp_if.color_code, want));
            end
         end
      end
   end

   // Watchdog: ends the run when no channel has moved a transfer for too long.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** tricorn_escape_time: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.point_re = '0;
      req_if.point_im = '0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.index    = '0;
      csr_if.wdata    = '0;
      cfg_max_iter    = ITER_WIDTH'(tce_pkg::MAX_ITER_RESET);
      cfg_radius_sq   = tce_pkg::RADIUS_RESET;
      cfg_rot_cos     = tce_pkg::ROT_COS_RESET;
      cfg_rot_sin     = tce_pkg::ROT_SIN_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);

      test_reset_defaults();
      test_zero_limit();
      test_zero_radius();
      test_square_overflow();
      test_iteration_extremes();
      test_rotation_extremes();
      test_unknown_index();
      test_random_traffic(0, 0);
      test_random_traffic(45, 0);
      test_random_traffic(0, 45);
      test_random_traffic(30, 30);
      test_backpressure();

      if (error_count == 0) begin
         $display("** tricorn_escape_time: PASSED **");
      end else begin
         $display("** tricorn_escape_time: FAILED **");
      end
      $finish;
   end

endmodule
